>>> hw/rtl/sawc_pkg.sv
// shared types and default sizes for the set-associative write-back cache
package sawc_pkg;

  localparam int unsigned DefSets      = 64;
  localparam int unsigned DefWays      = 4;
  localparam int unsigned DefLineBytes = 64;
  localparam int unsigned DefMemBytes  = 64 * 1024;

  localparam logic [15:0] LfsrSeed = 16'hACE1;

  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  localparam logic ModeLru    = 1'b0;
  localparam logic ModeRandom = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        hit;
    logic        wrote_back;
    logic [15:0] writeback_address;
  } out_word_t;

endpackage

>>> hw/rtl/set_assoc_writeback_cache_top.sv
// top level of the set-associative write-back write-allocate byte cache
// a hit passes lookup, commit, data read and done before its result loads
// miss: the line is filled from the backing memory, after a write-back when the victim is dirty;
//   a random eviction adds a state for the way select
// one word in flight, next word taken the cycle after the result loads; the byte-wide
//   backing memory port sets the miss time
// reset: the backing memory is cleared byte by byte, words held off meanwhile
module set_assoc_writeback_cache_top
  import sawc_pkg::*;
#(
  parameter int unsigned SETS       = DefSets,
  parameter int unsigned WAYS       = DefWays,
  parameter int unsigned LINE_BYTES = DefLineBytes,
  parameter int unsigned MEM_BYTES  = DefMemBytes
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  // geometry
  localparam int unsigned OFF_W  = $clog2(LINE_BYTES);
  localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
  localparam int unsigned LN_W   = ADDR_W - OFF_W;
  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned AGE_W  = WAY_W;
  localparam int unsigned ROW_W  = WAYS * (LN_W + 1 + AGE_W);
  localparam int unsigned LD_W   = SET_W + WAY_W + OFF_W;

  // reciprocal of WAYS scaled by 2**32, rounded up
  localparam logic [31:0] RND_RECIP =
    32'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;
  localparam logic [3:0] S_RAND   = 4'd3;
  localparam logic [3:0] S_COMMIT = 4'd4;
  localparam logic [3:0] S_HITRD  = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;

  // configuration and replacement state
  logic        mode;
  logic [15:0] lfsr;

  // valid bits per set, cleared at reset
  logic [WAYS-1:0] vld [2**SET_W];

  // latched access
  logic              kind_q;
  logic [7:0]        wdata_q;
  logic [LN_W-1:0]   line_q;
  logic [OFF_W-1:0]  off_q;
  logic [SET_W-1:0]  set_q;

  // latched set row
  logic [WAYS-1:0][LN_W-1:0]  tag_q;
  logic [WAYS-1:0]            dirty_q;
  logic [WAYS-1:0][AGE_W-1:0] age_q;
  logic [WAYS-1:0]            vld_q;

  logic [WAY_W-1:0] way_q;
  logic             hit_q;
  logic             found_q;
  logic             wb_q;
  logic [15:0]      wb_addr_q;
  logic [7:0]       rbyte_q;
  logic [OFF_W:0]   cnt;
  logic [ADDR_W-1:0] clr_cnt;

  // memory ports
  logic              row_we;
  logic [SET_W-1:0]  row_raddr;
  logic [ROW_W-1:0]  row_wdata;
  logic [ROW_W-1:0]  row_rdata;

  logic              ld_we;
  logic [LD_W-1:0]   ld_waddr;
  logic [7:0]        ld_wdata;
  logic [LD_W-1:0]   ld_raddr;
  logic [7:0]        ld_rdata;

  logic              bk_we;
  logic [ADDR_W-1:0] bk_waddr;
  logic [7:0]        bk_wdata;
  logic [ADDR_W-1:0] bk_raddr;
  logic [7:0]        bk_rdata;

  // incoming address split
  logic [ADDR_W-1:0] in_addr;
  logic [LN_W-1:0]   in_line;

  assign in_addr   = ADDR_W'(in_word.address);
  assign in_line   = in_addr[ADDR_W-1:OFF_W];
  assign row_raddr = SET_W'(in_line % SETS);

  assign in_ready = (state == S_IDLE);

  // set row: tags low, then dirty bits, then ages
  sawc_ram #(.WIDTH(ROW_W), .DEPTH(2**SET_W)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (set_q),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // cached line bytes, addressed {set, way, offset}
  sawc_ram #(.WIDTH(8), .DEPTH(2**LD_W)) u_line (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (ld_wdata),
    .raddr (ld_raddr),
    .rdata (ld_rdata)
  );

  // backing memory
  sawc_ram #(.WIDTH(8), .DEPTH(2**ADDR_W)) u_back (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  // row fields as read
  logic [WAYS-1:0][LN_W-1:0]  tag_r;
  logic [WAYS-1:0]            dirty_r;
  logic [WAYS-1:0][AGE_W-1:0] age_r;

  assign tag_r   = row_rdata[WAYS*LN_W-1:0];
  assign dirty_r = row_rdata[WAYS*LN_W +: WAYS];
  assign age_r   = row_rdata[WAYS*(LN_W+1) +: WAYS*AGE_W];

  // lookup: hit, first empty way, lru victim
  logic             hit_c;
  logic             found_c;
  logic [WAY_W-1:0] hway_c;
  logic [WAY_W-1:0] eway_c;
  logic [WAY_W-1:0] lway_c;
  logic [AGE_W-1:0] best_c;

  always_comb begin
    hit_c   = 1'b0;
    found_c = 1'b0;
    hway_c  = '0;
    eway_c  = '0;
    lway_c  = '0;
    best_c  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_c && vld[set_q][w] && tag_r[w] == line_q) begin
        hit_c  = 1'b1;
        hway_c = WAY_W'(w);
      end
      if (!found_c && !vld[set_q][w]) begin
        found_c = 1'b1;
        eway_c  = WAY_W'(w);
      end
      if (age_r[w] > best_c) begin
        best_c = age_r[w];
        lway_c = WAY_W'(w);
      end
    end
  end

  // next lfsr value: taps 16,14,13,11, shifting right
  logic [15:0] lfsr_step;
  assign lfsr_step = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};

  // random way: lfsr mod WAYS by reciprocal multiply, exact for 16-bit values
  logic [47:0] rnd_prod;
  logic [15:0] rnd_quo;
  logic [15:0] rnd_rem;
  assign rnd_prod = {16'd0, lfsr} * {16'd0, RND_RECIP};
  assign rnd_quo  = rnd_prod[47:32];
  assign rnd_rem  = lfsr - 16'(rnd_quo * 16'(WAYS));

  // commit: new ages, dirty bit and, on a miss, tag for the chosen way
  logic [WAYS-1:0][LN_W-1:0]  tag_n;
  logic [WAYS-1:0]            dirty_n;
  logic [WAYS-1:0][AGE_W-1:0] age_n;
  logic [AGE_W-1:0]           old_age;

  always_comb begin
    tag_n   = tag_q;
    dirty_n = dirty_q;
    age_n   = age_q;
    old_age = found_q ? AGE_W'(WAYS - 1) : age_q[way_q];
    for (int v = 0; v < WAYS; v++) begin
      if (WAY_W'(v) != way_q && vld_q[v] && age_q[v] < old_age) begin
        age_n[v] = age_q[v] + AGE_W'(1);
      end
    end
    age_n[way_q] = '0;
    if (hit_q) begin
      dirty_n[way_q] = dirty_q[way_q] | kind_q;
    end else begin
      dirty_n[way_q] = kind_q;
      tag_n[way_q]   = line_q;
    end
  end

  assign row_wdata = {age_n, dirty_n, tag_n};
  assign row_we    = (state == S_COMMIT);

  // byte sweeps: cnt issues the read, the write trails in the next cycle, once the registered read data is back
  logic [OFF_W-1:0] idx;
  logic             sweep_wr;
  logic             last;
  assign idx      = OFF_W'(cnt - (OFF_W+1)'(1));
  assign sweep_wr = (cnt != '0);
  assign last     = (cnt == (OFF_W+1)'(LINE_BYTES));

  // memory port muxing
  always_comb begin
    ld_we    = 1'b0;
    ld_waddr = {set_q, way_q, off_q};
    ld_wdata = wdata_q;
    ld_raddr = {set_q, way_q, cnt[OFF_W-1:0]};
    bk_we    = 1'b0;
    bk_waddr = {tag_q[way_q], idx};
    bk_wdata = ld_rdata;
    bk_raddr = {line_q, cnt[OFF_W-1:0]};
    unique case (state)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_cnt;
        bk_wdata = '0;
      end
      S_COMMIT: begin
        // hit: write the byte in place or read it
        ld_we    = hit_q && (kind_q == KindWrite);
        ld_raddr = {set_q, way_q, off_q};
      end
      S_WB: begin
        bk_we = sweep_wr;
      end
      S_FILL: begin
        ld_we    = sweep_wr;
        ld_waddr = {set_q, way_q, idx};
        ld_wdata = (kind_q == KindWrite && idx == off_q) ? wdata_q : bk_rdata;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      mode      <= ModeLru;
      lfsr      <= LfsrSeed;
      out_valid <= 1'b0;
      for (int s = 0; s < 2**SET_W; s++) begin
        vld[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      // result valid: loaded from done, dropped once taken
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_q  <= in_word.kind;
            wdata_q <= in_word.write_data;
            line_q  <= in_line;
            off_q   <= in_addr[OFF_W-1:0];
            set_q   <= row_raddr;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          tag_q   <= tag_r;
          dirty_q <= dirty_r;
          age_q   <= age_r;
          vld_q   <= vld[set_q];
          hit_q   <= hit_c;
          found_q <= !hit_c && found_c;
          wb_q    <= 1'b0;
          way_q   <= hit_c ? hway_c : (found_c ? eway_c : lway_c);
          if (!hit_c && !found_c && mode == ModeRandom) begin
            lfsr  <= lfsr_step;
            state <= S_RAND;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_RAND: begin
          way_q <= WAY_W'(rnd_rem);
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          vld[set_q][way_q] <= 1'b1;
          cnt <= '0;
          if (hit_q) begin
            state <= S_HITRD;
          end else if (!found_q && dirty_q[way_q]) begin
            wb_q      <= 1'b1;
            wb_addr_q <= 16'({tag_q[way_q], {OFF_W{1'b0}}});
            state     <= S_WB;
          end else begin
            state <= S_FILL;
          end
        end
        S_HITRD: begin
          rbyte_q <= (kind_q == KindWrite) ? wdata_q : ld_rdata;
          state   <= S_DONE;
        end
        S_WB: begin
          if (last) begin
            cnt   <= '0;
            state <= S_FILL;
          end else begin
            cnt <= cnt + (OFF_W+1)'(1);
          end
        end
        S_FILL: begin
          if (sweep_wr && idx == off_q) begin
            rbyte_q <= (kind_q == KindWrite) ? wdata_q : bk_rdata;
          end
          if (last) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + (OFF_W+1)'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_word.read_data         <= rbyte_q;
      out_word.hit               <= hit_q;
      out_word.wrote_back        <= wb_q;
      out_word.writeback_address <= wb_q ? wb_addr_q : 16'd0;
    end
  end

endmodule

>>> hw/rtl/sawc_ram.sv
// generic simple dual-port ram with registered read
module sawc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sawc_checker.sv
// port-level checks for the cache, bound to the top level
module sawc_checker
  import sawc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word,
  input logic      cfg_we,
  input logic      cfg_wdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  // no write-back means address zero
  a_wb_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.wrote_back |-> out_word.writeback_address == 16'd0)
    else $error("write-back address without write-back");

  // a write-back only happens on a miss
  a_wb_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.wrote_back |-> !out_word.hit)
    else $error("write-back on a hit");

endmodule

bind set_assoc_writeback_cache_top sawc_checker u_sawc_checker (.*);
